[hw/rtl/tpeu_pkg.sv]
// ----------------------------------------------------------------------------
// Tracker pattern event unpacker package
// Shared constants, status codes and the queue entry that passes from the
// byte classifier to the event decoder.
// ----------------------------------------------------------------------------
package tpeu_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned MaxChannelsDef = 32;
  localparam int unsigned MaxRowsDef     = 256;
  localparam int unsigned MaxPatternsDef = 256;

  // Depth of the queue between classifier and decoder.
  localparam int unsigned QueueDepthDef  = 4;

  // Field widths fixed by the packed format.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned RowCountW = 9;
  localparam int unsigned ChanCfgW  = 6;
  localparam int unsigned FieldNum  = 5;

  // Channel count after reset.
  localparam logic [ChanCfgW-1:0] ChanCountRst = 6'd1;

  // Bit 7 of the opening byte marks a mask byte.
  localparam int unsigned MaskFlagBit = 7;

  // Bits of the mask byte, one per event field, in field order.
  localparam logic [FieldNum-1:0] FieldNote  = 5'h01;
  localparam logic [FieldNum-1:0] FieldInstr = 5'h02;
  localparam logic [FieldNum-1:0] FieldVol   = 5'h04;
  localparam logic [FieldNum-1:0] FieldFxTyp = 5'h08;
  localparam logic [FieldNum-1:0] FieldFxArg = 5'h10;

  // Fields still pending after a plain note byte.
  localparam logic [FieldNum-1:0] NoteTailMask = FieldInstr | FieldVol | FieldFxTyp | FieldFxArg;

  // Status reported with a result.
  typedef enum logic [1:0] {
    StRun   = 2'd0,
    StDone  = 2'd1,
    StTrunc = 2'd2,
    StCount = 2'd3
  } status_e;

  // One classified byte.
  typedef struct packed {
    logic                 start;
    logic                 last;
    logic [RowCountW-1:0] rows;
    logic [ByteW-1:0]     data;
    logic [ByteW-1:0]     note;
    logic [FieldNum-1:0]  first_mask;
  } entry_t;

endpackage

[hw/rtl/tpeu_front.sv]
// ----------------------------------------------------------------------------
// Tracker pattern event unpacker: byte classifier
// Accepts packed bytes, clamps the row count and works out what an opening
// byte would mean, then pushes the result into the queue.
// ----------------------------------------------------------------------------
module tpeu_front
  import tpeu_pkg::*;
#(
  parameter int unsigned MAX_ROWS = MaxRowsDef
) (
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 start_of_pattern_i,
  input  logic [RowCountW-1:0] row_count_i,
  input  logic [ByteW-1:0]     data_byte_i,
  input  logic                 last_byte_i,
  input  logic                 q_ready_i,
  output logic                 q_push_o,
  output entry_t               q_entry_o
);

  localparam logic [RowCountW-1:0] RowsMax = RowCountW'(MAX_ROWS);

  logic                 is_mask;
  logic [RowCountW-1:0] rows_sat;

  // The request is taken whenever the queue has room.
  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i & q_ready_i;

  assign is_mask = data_byte_i[MaskFlagBit];

  // Zero rows counts as one; larger counts saturate.
  always_comb begin
    rows_sat = row_count_i;
    if (row_count_i == '0) begin
      rows_sat = RowCountW'(1);
    end else if (row_count_i > RowsMax) begin
      rows_sat = RowsMax;
    end
  end

  // Build the queue entry.
  always_comb begin
    q_entry_o.start      = start_of_pattern_i;
    q_entry_o.last       = last_byte_i;
    q_entry_o.rows       = rows_sat;
    q_entry_o.data       = data_byte_i;
    q_entry_o.note       = is_mask ? '0 : data_byte_i;
    q_entry_o.first_mask = is_mask ? data_byte_i[FieldNum-1:0] : NoteTailMask;
  end

endmodule

[hw/rtl/tpeu_queue.sv]
// ----------------------------------------------------------------------------
// Tracker pattern event unpacker: entry queue
// A short first-in first-out queue between classifier and decoder.
// ----------------------------------------------------------------------------
module tpeu_queue
  import tpeu_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   ready_o,
  output logic   valid_o,
  input  logic   pop_i,
  output entry_t entry_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  entry_t        mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign ready_o = (count_q != FullCnt);
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[hw/rtl/tpeu_back.sv]
// ----------------------------------------------------------------------------
// Tracker pattern event unpacker: event decoder
// Runs the packed-pattern parser on one queued byte per cycle while the result register is free
// or being emptied, keeps the row, channel and pattern counters and drives the registered result.
// ----------------------------------------------------------------------------
module tpeu_back
  import tpeu_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef,
  parameter int unsigned MAX_ROWS     = MaxRowsDef,
  parameter int unsigned MAX_PATTERNS = MaxPatternsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [ChanCfgW-1:0] channel_count_i,
  input  logic                q_valid_i,
  input  entry_t              q_entry_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                event_valid_o,
  output logic [ByteW-1:0]    pattern_number_o,
  output logic [ByteW-1:0]    row_number_o,
  output logic [4:0]          channel_number_o,
  output logic [ByteW-1:0]    note_value_o,
  output logic [ByteW-1:0]    instrument_value_o,
  output logic [ByteW-1:0]    volume_value_o,
  output logic [ByteW-1:0]    effect_kind_o,
  output logic [ByteW-1:0]    effect_argument_o,
  output logic [1:0]          status_o
);

  localparam int unsigned RW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned PW   = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int unsigned ACW  = ChanCfgW + 1;
  localparam logic [PW-1:0]  PatLast = PW'(MAX_PATTERNS - 1);
  localparam logic [ACW-1:0] ChanMax = ACW'(MAX_CHANNELS);

  // Configuration and parser state.
  logic [ChanCfgW-1:0] chan_cfg_q;
  logic                phase_q, phase_d;
  logic [FieldNum-1:0] mask_q, mask_d;
  logic [ByteW-1:0]    fields_q [FieldNum];
  logic [ByteW-1:0]    fields_d [FieldNum];
  logic [RW-1:0]       row_q, row_d;
  logic [RW-1:0]       rows_q, rows_d;
  logic [CHW-1:0]      chan_q, chan_d;
  logic [PW-1:0]       pat_q, pat_d;
  logic                skip_q, skip_d;

  // Working values of one step.
  logic [ACW-1:0] active;
  status_e        st;
  logic           emit, drop, found, pop, load;
  logic [RW-1:0]  ev_row;
  logic [CHW-1:0] ev_chan;
  logic [31:0]    pat_wide, row_wide, chan_wide;

  // Result register.
  logic              out_valid_q;
  logic              out_event_q;
  logic [ByteW-1:0]  out_pat_q;
  logic [ByteW-1:0]  out_row_q;
  logic [4:0]        out_chan_q;
  logic [ByteW-1:0]  out_fields_q [FieldNum];
  status_e           out_status_q;

  // A byte is taken when the result register is free or being emptied.
  assign pop     = q_valid_i & (~out_valid_q | out_ready_i);
  assign q_pop_o = pop;

  // Channels per row, with zero taken as one and a ceiling at the maximum.
  always_comb begin
    active = ACW'(chan_cfg_q);
    if (chan_cfg_q == '0) begin
      active = ACW'(1);
    end else if (ACW'(chan_cfg_q) > ChanMax) begin
      active = ChanMax;
    end
  end

  // Parser step for the byte at the head of the queue.
  always_comb begin
    phase_d  = phase_q;
    mask_d   = mask_q;
    fields_d = fields_q;
    row_d    = row_q;
    rows_d   = rows_q;
    chan_d   = chan_q;
    pat_d    = pat_q;
    skip_d   = skip_q;
    st       = StRun;
    emit     = 1'b0;
    drop     = 1'b0;
    found    = 1'b0;
    ev_row   = '0;
    ev_chan  = '0;

    // A start opens a new pattern and abandons any old one.
    if (q_entry_i.start) begin
      pat_d    = (pat_q == PatLast) ? '0 : pat_q + 1'b1;
      rows_d   = RW'(q_entry_i.rows);
      row_d    = '0;
      chan_d   = '0;
      phase_d  = 1'b0;
      mask_d   = '0;
      skip_d   = 1'b0;
      for (int i = 0; i < FieldNum; i++) begin
        fields_d[i] = '0;
      end
    end else if (skip_q) begin
      drop = 1'b1;
    end

    if (!drop) begin
      if (!phase_d) begin
        // Opening byte: too many events, or a mask or a note.
        if (row_d >= rows_d) begin
          st = StCount;
        end else begin
          fields_d[0] = q_entry_i.note;
          for (int i = 1; i < FieldNum; i++) begin
            fields_d[i] = '0;
          end
          mask_d  = q_entry_i.first_mask;
          phase_d = 1'b1;
        end
      end else begin
        // Following byte fills the lowest pending field.
        for (int i = 0; i < FieldNum; i++) begin
          if (!found && mask_d[i]) begin
            fields_d[i] = q_entry_i.data;
            mask_d[i]   = 1'b0;
            found       = 1'b1;
          end
        end
      end

      // Event complete: report it if not empty and advance the position.
      if (st == StRun && phase_d && mask_d == '0) begin
        phase_d = 1'b0;
        emit    = (fields_d[0] != '0) || (fields_d[1] != '0) || (fields_d[2] != '0) ||
                  (fields_d[3] != '0) || (fields_d[4] != '0);
        ev_row  = row_d;
        ev_chan = chan_d;
        if (ACW'(chan_d) + ACW'(1) >= active) begin
          chan_d = '0;
          row_d  = row_d + 1'b1;
        end else begin
          chan_d = chan_d + 1'b1;
        end
      end

      // End of the pattern data: check for a truncated event and the event count.
      if (st == StRun && q_entry_i.last) begin
        if (phase_d) begin
          st = StTrunc;
        end else if (row_d != rows_d || chan_d != '0) begin
          st = StCount;
        end else begin
          st = StDone;
        end
      end

      if (st != StRun) begin
        skip_d  = 1'b1;
        phase_d = 1'b0;
        mask_d  = '0;
      end
    end
  end

  assign load      = pop & (emit | (st != StRun));
  assign pat_wide  = 32'(pat_d);
  assign row_wide  = 32'(ev_row);
  assign chan_wide = 32'(ev_chan);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cfg_q  <= ChanCountRst;
      phase_q     <= 1'b0;
      mask_q      <= '0;
      row_q       <= '0;
      rows_q      <= RW'(1);
      chan_q      <= '0;
      pat_q       <= PatLast;
      skip_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        chan_cfg_q <= channel_count_i;
      end
      if (pop) begin
        phase_q <= phase_d;
        mask_q  <= mask_d;
        row_q   <= row_d;
        rows_q  <= rows_d;
        chan_q  <= chan_d;
        pat_q   <= pat_d;
        skip_q  <= skip_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Event bytes and result payload.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      fields_q <= fields_d;
    end
    if (load) begin
      out_event_q  <= emit;
      out_pat_q    <= pat_wide[ByteW-1:0];
      out_row_q    <= emit ? row_wide[ByteW-1:0] : '0;
      out_chan_q   <= emit ? chan_wide[4:0] : '0;
      out_status_q <= st;
      for (int i = 0; i < FieldNum; i++) begin
        out_fields_q[i] <= emit ? fields_d[i] : '0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign event_valid_o      = out_event_q;
  assign pattern_number_o   = out_pat_q;
  assign row_number_o       = out_row_q;
  assign channel_number_o   = out_chan_q;
  assign note_value_o       = out_fields_q[0];
  assign instrument_value_o = out_fields_q[1];
  assign volume_value_o     = out_fields_q[2];
  assign effect_kind_o      = out_fields_q[3];
  assign effect_argument_o  = out_fields_q[4];
  assign status_o           = out_status_q;

endmodule

[hw/rtl/tracker_pattern_event_unpacker_core.sv]
// ----------------------------------------------------------------------------
// Tracker pattern event unpacker
// Decodes packed tracker pattern bytes into note events with row, channel
// and pattern position, and reports a status at the end of each pattern.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one packed byte per request, with its start and
//   last flags and the row count sampled on the start byte. The output
//   channel carries one result per non-empty event or per status. The
//   configuration channel writes the channel count and is always ready; write
//   it only while no bytes are in flight.
//   Path: an accepted byte is written into the queue, and the decoder then
//   takes it from the queue head and loads its result into the result register.
//   Throughput: one byte per cycle, set by the decoder step, while the result register is free or being emptied.
//   A byte that ends no event and raises no status yields no result.
//   Reset: the queue and result register empty, the channel count becomes
//   one, and bytes are dropped until the first start byte.
//   Stalls: when the receiver holds ready low the result waits in its
//   register, the decoder stops, and the four-entry queue absorbs incoming
//   bytes; the input ready falls only when that queue is full.
// ----------------------------------------------------------------------------
module tracker_pattern_event_unpacker_core
  import tpeu_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef,
  parameter int unsigned MAX_ROWS     = MaxRowsDef,
  parameter int unsigned MAX_PATTERNS = MaxPatternsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [ChanCfgW-1:0]  channel_count_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 start_of_pattern_i,
  input  logic [RowCountW-1:0] row_count_i,
  input  logic [ByteW-1:0]     data_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 event_valid_o,
  output logic [ByteW-1:0]     pattern_number_o,
  output logic [ByteW-1:0]     row_number_o,
  output logic [4:0]           channel_number_o,
  output logic [ByteW-1:0]     note_value_o,
  output logic [ByteW-1:0]     instrument_value_o,
  output logic [ByteW-1:0]     volume_value_o,
  output logic [ByteW-1:0]     effect_kind_o,
  output logic [ByteW-1:0]     effect_argument_o,
  output logic [1:0]           status_o
);

  logic   q_ready, q_push, q_valid, q_pop;
  entry_t push_entry, head_entry;

  // The channel count register takes every write at once.
  assign cfg_ready_o = 1'b1;

  // Classifier.
  tpeu_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .start_of_pattern_i (start_of_pattern_i),
    .row_count_i        (row_count_i),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .q_ready_i          (q_ready),
    .q_push_o           (q_push),
    .q_entry_o          (push_entry)
  );

  // Queue between classifier and decoder.
  tpeu_queue #(
    .DEPTH (QueueDepthDef)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (head_entry)
  );

  // Decoder and result register.
  tpeu_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_ROWS     (MAX_ROWS),
    .MAX_PATTERNS (MAX_PATTERNS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .channel_count_i    (channel_count_i),
    .q_valid_i          (q_valid),
    .q_entry_i          (head_entry),
    .q_pop_o            (q_pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .event_valid_o      (event_valid_o),
    .pattern_number_o   (pattern_number_o),
    .row_number_o       (row_number_o),
    .channel_number_o   (channel_number_o),
    .note_value_o       (note_value_o),
    .instrument_value_o (instrument_value_o),
    .volume_value_o     (volume_value_o),
    .effect_kind_o      (effect_kind_o),
    .effect_argument_o  (effect_argument_o),
    .status_o           (status_o)
  );

endmodule
